### rtl/core/assert_macros.svh
// Assertion helpers shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define GCPA_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Same-cycle implication.
`define GCPA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

`endif

### rtl/core/gcpa_pkg.sv
// ----------------------------------------------------------------------------
// gcpa_pkg
// Shared widths, codes and sequencer states of the coarse-cell pooling block.
// ----------------------------------------------------------------------------
package gcpa_pkg;

	localparam int ELEV_W           = 32;
	localparam int ACC_W            = 64;
	localparam int DIV_STEPS        = 64;
	localparam int STEP_W           = 7;
	localparam int CFG_W            = 7;
	localparam int ERR_W            = 2;
	localparam int CMP_W            = 10;
	localparam int MAX_CHILDREN_DEF = 64;

	localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
	localparam logic [ERR_W-1:0] ERR_TOO_MANY = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLOSE,
		ST_MEAN,
		ST_VAR,
		ST_VDIV,
		ST_EMIT
	} state_t;

endpackage

### rtl/core/gcpa_if.sv
// ----------------------------------------------------------------------------
// gcpa_if
// Request channels of the pooling block: child cells in, parent cells out.
// ----------------------------------------------------------------------------
interface gcpa_child_if;
	logic                                valid;
	logic                                ready;
	logic signed [gcpa_pkg::ELEV_W-1:0] elevation;
	logic                                valid_req;
	logic                                obstacle;
	logic signed [gcpa_pkg::ELEV_W-1:0] obst_height;
	logic [gcpa_pkg::ELEV_W-1:0]        age_ms;
	logic                                quality;
	logic [gcpa_pkg::ELEV_W-1:0]        elevation_spread;
	logic [gcpa_pkg::ELEV_W-1:0]        obstacle_spread;
	logic [gcpa_pkg::ELEV_W-1:0]        seen_count;
	logic                                forbidden;
	logic                                last_child;

	modport source (output valid, elevation, valid_req, obstacle, obst_height, age_ms,
		quality, elevation_spread, obstacle_spread, seen_count, forbidden, last_child,
		input ready);
	modport sink (input valid, elevation, valid_req, obstacle, obst_height, age_ms,
		quality, elevation_spread, obstacle_spread, seen_count, forbidden, last_child,
		output ready);
endinterface

interface gcpa_parent_if;
	logic                                valid;
	logic                                ready;
	logic signed [gcpa_pkg::ELEV_W-1:0] mean_elevation;
	logic                                parent_valid;
	logic                                parent_obstacle;
	logic                                parent_forbidden;
	logic signed [gcpa_pkg::ELEV_W-1:0] max_obstacle_height;
	logic [gcpa_pkg::ELEV_W-1:0]        max_age_ms;
	logic                                parent_quality;
	logic [gcpa_pkg::ELEV_W-1:0]        min_seen_count;
	logic [gcpa_pkg::ELEV_W-1:0]        max_obstacle_spread;
	logic [gcpa_pkg::ELEV_W-1:0]        total_elevation_spread;
	logic [gcpa_pkg::ERR_W-1:0]         error_code;

	modport source (output valid, mean_elevation, parent_valid, parent_obstacle,
		parent_forbidden, max_obstacle_height, max_age_ms, parent_quality, min_seen_count,
		max_obstacle_spread, total_elevation_spread, error_code, input ready);
	modport sink (input valid, mean_elevation, parent_valid, parent_obstacle,
		parent_forbidden, max_obstacle_height, max_age_ms, parent_quality, min_seen_count,
		max_obstacle_spread, total_elevation_spread, error_code, output ready);
endinterface

### rtl/core/grid_cell_pyramid_aggregator.sv
// ----------------------------------------------------------------------------
// grid_cell_pyramid_aggregator
// Pools child map cells into one coarse parent cell (min/max/mean/variance).
// ----------------------------------------------------------------------------
// A child that does not close its group is taken while the block is idle.
// The child marked last_child closes the group: a decision state, then for a
// complete all-valid group a divider pass for the mean, a squared-delta pass
// over the stored elevations (one memory read a cycle, one 32x32 multiply) and
// a second divider pass for the variance; other groups go straight from the
// decision state to emit. The bit-serial divider paces both divider passes.
// No child is taken while a group closes; a finished parent waits in its own
// output register, so the next group may start before it is taken.
module grid_cell_pyramid_aggregator #(
	parameter int MaxChildren = gcpa_pkg::MAX_CHILDREN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [gcpa_pkg::CFG_W-1:0]    cfg_wr_data,
	gcpa_child_if.sink                    child,
	gcpa_parent_if.source                 parent
);
	import gcpa_pkg::*;

	`include "assert_macros.svh"

	localparam int AddrW  = (MaxChildren > 1) ? $clog2(MaxChildren) : 1;
	localparam int CntW   = $clog2(MaxChildren + 2);
	localparam int TotalW = ELEV_W + AddrW;

	state_t state_q, state_d;

	logic [CFG_W-1:0]         cfg_q;
	logic [CntW-1:0]          cnt_q;
	logic signed [TotalW-1:0] total_q;
	logic                     run_valid_q, run_obst_q, run_forb_q, run_qual_q;
	logic signed [ELEV_W-1:0] run_height_q;
	logic [ELEV_W-1:0]        run_age_q, run_cnt_q, run_ospread_q, run_espread_q;

	logic [ELEV_W-1:0]        mem [MaxChildren];
	logic [ELEV_W-1:0]        rd_data_s1;
	logic                     v_s1, v_s2;
	logic [2*ELEV_W-1:0]      sq_s2;
	logic [ACC_W-1:0]         acc_q;
	logic [CntW-1:0]          idx_q;
	logic signed [ELEV_W-1:0] mean_q;
	logic [ELEV_W-1:0]        tot_q;

	logic                     accept, div_start, div_done, rd_issue, out_load, var_done;
	logic [ACC_W-1:0]         div_dividend, div_quot;
	logic [CMP_W-1:0]         n_c, expect_c;
	logic                     too_many, complete, all_valid;
	logic [TotalW-1:0]        total_abs;
	logic signed [ELEV_W:0]   delta;
	logic [ELEV_W-1:0]        delta_abs;
	logic [ACC_W:0]           acc_sum;
	logic [ACC_W:0]           var_sum;
	logic                     out_valid_q;

	assign accept   = child.valid && child.ready;
	assign n_c      = CMP_W'(cnt_q);
	assign expect_c = (CMP_W'(cfg_q) > CMP_W'(MaxChildren)) ? CMP_W'(MaxChildren)
		: CMP_W'(cfg_q);
	assign too_many  = n_c > expect_c;
	assign complete  = n_c == expect_c;
	assign all_valid = complete && run_valid_q;
	assign total_abs = total_q[TotalW-1] ? TotalW'(-total_q) : TotalW'(total_q);
	assign var_done  = (idx_q == cnt_q) && !v_s1 && !v_s2;
	assign div_dividend = (state_q == ST_CLOSE) ? ACC_W'(total_abs) : acc_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && child.last_child) state_d = ST_CLOSE;
			ST_CLOSE: state_d = (!too_many && all_valid) ? ST_MEAN : ST_EMIT;
			ST_MEAN:  if (div_done) state_d = ST_VAR;
			ST_VAR:   if (var_done) state_d = ST_VDIV;
			ST_VDIV:  if (div_done) state_d = ST_EMIT;
			ST_EMIT:  if (!out_valid_q || parent.ready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		child.ready = 1'b0;
		div_start   = 1'b0;
		rd_issue    = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ST_IDLE:  child.ready = 1'b1;
			ST_CLOSE: div_start   = !too_many && all_valid;
			ST_VAR: begin
				rd_issue  = idx_q < cnt_q;
				div_start = var_done;
			end
			ST_EMIT:  out_load    = !out_valid_q || parent.ready;
			default: ;
		endcase
	end

	gcpa_div #(.CntW(CntW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cfg_q         <= CFG_W'(1);
			cnt_q         <= '0;
			total_q       <= '0;
			run_valid_q   <= 1'b1;
			run_obst_q    <= 1'b0;
			run_forb_q    <= 1'b0;
			run_qual_q    <= 1'b1;
			run_height_q  <= '0;
			run_age_q     <= '0;
			run_cnt_q     <= '1;
			run_ospread_q <= '0;
			run_espread_q <= '0;
			v_s1          <= 1'b0;
			v_s2          <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) cfg_q <= cfg_wr_data;
			v_s1 <= rd_issue;
			v_s2 <= v_s1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (parent.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				if (cnt_q <= CntW'(MaxChildren)) cnt_q <= cnt_q + 1'b1;
				total_q     <= total_q + TotalW'(child.elevation);
				run_valid_q <= run_valid_q & child.valid_req;
				run_obst_q  <= run_obst_q | child.obstacle;
				run_forb_q  <= run_forb_q | child.forbidden;
				run_qual_q  <= run_qual_q & child.quality;
				if (child.obst_height > run_height_q) run_height_q <= child.obst_height;
				if (child.age_ms > run_age_q) run_age_q <= child.age_ms;
				if (child.seen_count < run_cnt_q) run_cnt_q <= child.seen_count;
				if (child.obstacle_spread > run_ospread_q) run_ospread_q <= child.obstacle_spread;
				if (child.elevation_spread > run_espread_q)
					run_espread_q <= child.elevation_spread;
			end else if (out_load) begin
				cnt_q         <= '0;
				total_q       <= '0;
				run_valid_q   <= 1'b1;
				run_obst_q    <= 1'b0;
				run_forb_q    <= 1'b0;
				run_qual_q    <= 1'b1;
				run_height_q  <= '0;
				run_age_q     <= '0;
				run_cnt_q     <= '1;
				run_ospread_q <= '0;
				run_espread_q <= '0;
			end
		end
	end

	// elevation store
	always_ff @(posedge clk) begin
		if (accept && (cnt_q < CntW'(MaxChildren))) mem[cnt_q[AddrW-1:0]] <= child.elevation;
		if (rd_issue) rd_data_s1 <= mem[idx_q[AddrW-1:0]];
	end

	assign delta     = (ELEV_W+1)'($signed(rd_data_s1)) - (ELEV_W+1)'(mean_q);
	assign delta_abs = delta[ELEV_W] ? ELEV_W'(-delta) : ELEV_W'(delta);
	assign acc_sum   = {1'b0, acc_q} + (ACC_W+1)'(sq_s2);
	assign var_sum   = {1'b0, div_quot} + (ACC_W+1)'(run_espread_q);

	always_ff @(posedge clk) begin
		if (state_q == ST_MEAN && div_done) begin
			mean_q <= total_q[TotalW-1] ? -$signed(div_quot[ELEV_W-1:0])
				: $signed(div_quot[ELEV_W-1:0]);
			idx_q  <= '0;
			acc_q  <= '0;
		end
		if (rd_issue) idx_q <= idx_q + 1'b1;
		if (v_s1) sq_s2 <= delta_abs * delta_abs;
		if (v_s2) acc_q <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
		if (state_q == ST_VDIV && div_done)
			tot_q <= (var_sum[ACC_W:ELEV_W] != '0) ? '1 : var_sum[ELEV_W-1:0];
	end

	// parent output register
	always_ff @(posedge clk) begin
		if (out_load) begin
			if (too_many) begin
				parent.mean_elevation         <= '0;
				parent.parent_valid           <= 1'b0;
				parent.parent_obstacle        <= 1'b0;
				parent.parent_forbidden       <= 1'b0;
				parent.max_obstacle_height    <= '0;
				parent.max_age_ms             <= '0;
				parent.parent_quality         <= 1'b0;
				parent.min_seen_count         <= '0;
				parent.max_obstacle_spread    <= '0;
				parent.total_elevation_spread <= '0;
				parent.error_code             <= ERR_TOO_MANY;
			end else begin
				parent.mean_elevation         <= all_valid ? mean_q : '0;
				parent.parent_valid           <= all_valid;
				parent.parent_obstacle        <= run_obst_q;
				parent.parent_forbidden       <= run_forb_q | !complete;
				parent.max_obstacle_height    <= run_height_q;
				parent.max_age_ms             <= run_age_q;
				parent.parent_quality         <= run_qual_q & complete;
				parent.min_seen_count         <= complete ? run_cnt_q : '0;
				parent.max_obstacle_spread    <= run_ospread_q;
				parent.total_elevation_spread <= all_valid ? tot_q : run_espread_q;
				parent.error_code             <= ERR_NONE;
			end
		end
	end

	assign parent.valid = out_valid_q;

	`GCPA_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CntW'(MaxChildren + 1))
	`GCPA_ASSERT_IMP(a_load_free, clk, arst_n, out_load, !out_valid_q || parent.ready)
	`GCPA_ASSERT_IMP(a_err_zero, clk, arst_n,
		out_valid_q && parent.error_code == ERR_TOO_MANY,
		!parent.parent_valid && parent.mean_elevation == '0)

endmodule

### rtl/core/gcpa_div.sv
// ----------------------------------------------------------------------------
// gcpa_div
// Restoring unsigned divider, one quotient bit per cycle, shared by the
// mean and variance steps.
// ----------------------------------------------------------------------------
module gcpa_div #(
	parameter int CntW = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [gcpa_pkg::ACC_W-1:0]     dividend,
	input  logic [CntW-1:0]                divisor,
	output logic                           done,
	output logic [gcpa_pkg::ACC_W-1:0]     quotient
);
	import gcpa_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [CntW-1:0]   rem_q;
	logic [CntW-1:0]   div_q;
	logic [ACC_W-1:0]  work_q;
	logic [CntW:0]     trial;
	logic              fits;
	logic [CntW:0]     diff;

	assign trial = {rem_q, work_q[ACC_W-1]};
	assign fits  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			div_q  <= divisor;
			work_q <= dividend;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[CntW-1:0] : trial[CntW-1:0];
			work_q <= {work_q[ACC_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the coarse-cell pooling block. Child requests are
// driven with random gaps, parent requests taken with random back-pressure and
// compared field by field against a behavioural predictor of the pooling
// rules, across several child-count settings including both extremes.
// ----------------------------------------------------------------------------
module tb_top;
	import gcpa_pkg::*;

	typedef struct {
		logic signed [31:0] elevation;
		logic               valid_req;
		logic               obstacle;
		logic signed [31:0] obst_height;
		logic [31:0]        age_ms;
		logic               quality;
		logic [31:0]        elevation_spread;
		logic [31:0]        obstacle_spread;
		logic [31:0]        seen_count;
		logic               forbidden;
		logic               last_child;
	} child_t;

	typedef struct {
		logic signed [31:0] mean_elevation;
		logic               parent_valid;
		logic               parent_obstacle;
		logic               parent_forbidden;
		logic signed [31:0] max_obstacle_height;
		logic [31:0]        max_age_ms;
		logic               parent_quality;
		logic [31:0]        min_seen_count;
		logic [31:0]        max_obstacle_spread;
		logic [31:0]        total_elevation_spread;
		logic [ERR_W-1:0]   error_code;
	} parent_t;

	typedef struct {
		bit          wr;
		logic [6:0]  cfg;
		child_t      c;
		bit          fixed;
		parent_t     p;
	} row_t;

	localparam int POOL_MAX = 64;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	gcpa_child_if  child ();
	gcpa_parent_if parent ();

	grid_cell_pyramid_aggregator u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.child      (child),
		.parent     (parent)
	);

	// pooling predictor state
	logic [6:0]         pool_expected;
	logic signed [31:0] pool_elev [POOL_MAX];
	int unsigned        pool_seen;
	longint             pool_total;
	logic               pool_valid, pool_obst, pool_forb, pool_qual;
	longint             pool_height;
	logic [31:0]        pool_age, pool_cnt, pool_ospread, pool_espread;

	parent_t parent_q[$];
	int      mismatches;
	bit      steady;
	int      hold_token, hold_seen, hold_left;
	row_t    rows[$];

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic void pool_clear();
		pool_seen = 0;
		pool_total = 0;
		pool_valid = 1;
		pool_obst = 0;
		pool_forb = 0;
		pool_qual = 1;
		pool_height = 0;
		pool_age = 0;
		pool_cnt = '1;
		pool_ospread = 0;
		pool_espread = 0;
	endfunction

	function automatic bit pool_step(input child_t c, output parent_t p);
		int unsigned eff, n;
		logic v, f, q;
		logic [31:0] mc;
		longint mean, d;
		longint unsigned acc, sq, ad, var_sum;
		p = '{default: 0};
		if (pool_seen < POOL_MAX)
			pool_elev[pool_seen] = c.elevation;
		if (pool_seen <= POOL_MAX)
			pool_seen++;
		pool_valid &= c.valid_req;
		pool_obst |= c.obstacle;
		if (longint'(c.obst_height) > pool_height)
			pool_height = longint'(c.obst_height);
		if (c.age_ms > pool_age)
			pool_age = c.age_ms;
		pool_qual &= c.quality;
		if (c.elevation_spread > pool_espread)
			pool_espread = c.elevation_spread;
		if (c.obstacle_spread > pool_ospread)
			pool_ospread = c.obstacle_spread;
		if (c.seen_count < pool_cnt)
			pool_cnt = c.seen_count;
		pool_forb |= c.forbidden;
		pool_total += longint'(c.elevation);
		if (!c.last_child)
			return 0;
		eff = (pool_expected > POOL_MAX) ? POOL_MAX : pool_expected;
		n = pool_seen;
		if (n > eff) begin
			p.error_code = ERR_TOO_MANY;
			pool_clear();
			return 1;
		end
		v = pool_valid;
		f = pool_forb;
		q = pool_qual;
		mc = pool_cnt;
		if (n != eff) begin
			v = 0;
			f = 1;
			q = 0;
			mc = 0;
		end
		mean = 0;
		p.total_elevation_spread = pool_espread;
		if (v) begin
			acc = 0;
			mean = pool_total / longint'(n);
			for (int i = 0; i < n; i++) begin
				d = longint'(pool_elev[i]) - mean;
				ad = (d < 0) ? longint'(-d) : d;
				sq = ad * ad;
				acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
			end
			var_sum = acc / n + pool_espread;
			p.total_elevation_spread = (var_sum > 64'hFFFF_FFFF) ? '1 : var_sum[31:0];
		end
		p.mean_elevation = mean[31:0];
		p.parent_valid = v;
		p.parent_obstacle = pool_obst;
		p.parent_forbidden = f;
		p.max_obstacle_height = pool_height[31:0];
		p.max_age_ms = pool_age;
		p.parent_quality = q;
		p.min_seen_count = mc;
		p.max_obstacle_spread = pool_ospread;
		p.error_code = ERR_NONE;
		pool_clear();
		return 1;
	endfunction

	function automatic child_t mk(logic [31:0] el, logic vr, logic ob, logic [31:0] ht,
			logic [31:0] age, logic ql, logic [31:0] es, logic [31:0] os, logic [31:0] cnt,
			logic fb, logic lc);
		return '{el, vr, ob, ht, age, ql, es, os, cnt, fb, lc};
	endfunction

	function automatic void add_row(row_t rr);
		rows.insert(rows.size(), rr);
	endfunction

	function automatic logic [31:0] pick32();
		case ($urandom_range(0, 7))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	task automatic drain();
		while (parent_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_children(logic [6:0] v);
		drain();
		cfg_wr_en <= 1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 0;
		pool_expected = v;
	endtask

	task automatic send(child_t c, bit fixed, parent_t fp);
		parent_t p;
		while (!steady && $urandom_range(0, 99) < 23) begin
			child.valid <= 0;
			@(posedge clk);
		end
		child.valid <= 1;
		child.elevation <= c.elevation;
		child.valid_req <= c.valid_req;
		child.obstacle <= c.obstacle;
		child.obst_height <= c.obst_height;
		child.age_ms <= c.age_ms;
		child.quality <= c.quality;
		child.elevation_spread <= c.elevation_spread;
		child.obstacle_spread <= c.obstacle_spread;
		child.seen_count <= c.seen_count;
		child.forbidden <= c.forbidden;
		child.last_child <= c.last_child;
		do
			@(posedge clk);
		while (!child.ready);
		if (pool_step(c, p))
			parent_q.insert(parent_q.size(), fixed ? fp : p);
	endtask

	task automatic idle_child();
		child.valid <= 0;
		@(posedge clk);
	endtask

	// random child, elevation drawn wide or narrow per group
	function automatic child_t rand_child(bit wide, bit last);
		child_t c;
		c = mk(wide ? pick32() : 32'($urandom_range(0, 20000)) - 32'd10000,
			$urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)), pick32(), pick32(),
			$urandom_range(0, 5) != 0, $urandom_range(0, 3) == 0 ? pick32() : $urandom_range(0, 5000),
			pick32(), pick32(), $urandom_range(0, 5) == 0, last);
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parent.ready <= 0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= 400;
			parent.ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			parent.ready <= 0;
		end else begin
			parent.ready <= steady || ($urandom_range(0, 99) >= 23);
		end
	end

	task automatic field_chk(string name, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%t mismatch %s: expected %h actual %h", $realtime, name, e, a);
		end
	endtask

	always @(posedge clk) begin
		parent_t e;
		if (arst_n && parent.valid && parent.ready) begin
			if (parent_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%t parent request with nothing outstanding", $realtime);
			end else begin
				e = parent_q[0];
				parent_q.delete(0);
				field_chk("mean_elevation", e.mean_elevation, parent.mean_elevation);
				field_chk("parent_valid", 32'(e.parent_valid), 32'(parent.parent_valid));
				field_chk("parent_obstacle", 32'(e.parent_obstacle),
					32'(parent.parent_obstacle));
				field_chk("parent_forbidden", 32'(e.parent_forbidden),
					32'(parent.parent_forbidden));
				field_chk("max_obstacle_height", e.max_obstacle_height,
					parent.max_obstacle_height);
				field_chk("max_age_ms", e.max_age_ms, parent.max_age_ms);
				field_chk("parent_quality", 32'(e.parent_quality), 32'(parent.parent_quality));
				field_chk("min_seen_count", e.min_seen_count, parent.min_seen_count);
				field_chk("max_obstacle_spread", e.max_obstacle_spread,
					parent.max_obstacle_spread);
				field_chk("total_elevation_spread", e.total_elevation_spread,
					parent.total_elevation_spread);
				field_chk("error_code", 32'(e.error_code), 32'(parent.error_code));
			end
		end
	end

	initial begin
		parent_t zero_p, fp;
		row_t r;
		logic [6:0] settings[$];
		int unsigned eff, size, budget;
		bit wide;

		zero_p = '{default: 0};
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_wr_data = 0;
		child.valid = 0;
		child.elevation = 0;
		child.valid_req = 0;
		child.obstacle = 0;
		child.obst_height = 0;
		child.age_ms = 0;
		child.quality = 0;
		child.elevation_spread = 0;
		child.obstacle_spread = 0;
		child.seen_count = 0;
		child.forbidden = 0;
		child.last_child = 0;
		mismatches = 0;
		steady = 0;
		hold_token = 0;
		pool_expected = 1;
		pool_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed rows; expected values typed where obvious
		fp = '{32'sh7FFF_FFFF, 1, 1, 1, 32'sh7FFF_FFFF, '1, 1, '1, '1, '1, ERR_NONE};
		add_row('{0, 0, mk('h7FFF_FFFF, 1, 1, 'h7FFF_FFFF, '1, 1, '1, '1, '1, 1, 1),
			1, fp});
		fp = '{32'sh8000_0000, 1, 0, 0, 0, 0, 1, 0, 0, 0, ERR_NONE};
		add_row('{0, 0, mk('h8000_0000, 1, 0, 'h8000_0000, 0, 1, 0, 0, 0, 0, 1),
			1, fp});
		add_row('{0, 0, mk(5, 1, 0, 7, 9, 1, 3, 4, 8, 0, 0), 0, zero_p});
		fp = zero_p;
		fp.error_code = ERR_TOO_MANY;
		add_row('{0, 0, mk(6, 1, 1, 2, 3, 1, 5, 6, 7, 1, 1), 1, fp});
		add_row('{0, 0, mk(-77, 0, 0, -3, 12, 1, 900, 4, 8, 0, 1), 0, zero_p});
		add_row('{1, 0, mk(1, 1, 0, 1, 1, 1, 1, 1, 1, 0, 1), 1, fp});
		add_row('{1, 4, mk(100, 1, 0, 50, 10, 1, 20, 30, 40, 0, 0), 0, zero_p});
		add_row('{0, 0, mk(-200, 1, 1, 60, 5, 1, 10, 3, 9, 0, 0), 0, zero_p});
		add_row('{0, 0, mk(301, 1, 0, -9, 70, 1, 0, 2, 50, 0, 1), 0, zero_p});
		add_row('{0, 0, mk(-1000, 1, 0, 5, 1, 1, 12, 1, 6, 0, 0), 0, zero_p});
		add_row('{0, 0, mk(2047, 1, 1, 99, 2, 1, 4, 8, 3, 0, 0), 0, zero_p});
		add_row('{0, 0, mk(-3, 1, 0, 1, 3, 1, 77, 0, 4, 0, 0), 0, zero_p});
		add_row('{0, 0, mk(9, 1, 0, 2, 4, 1, 5, 5, 5, 0, 1), 0, zero_p});
		add_row('{0, 0, mk(1, 1, 0, 0, 0, 0, 0, 0, 9, 1, 0), 0, zero_p});
		add_row('{0, 0, mk(2, 1, 0, 0, 0, 1, 0, 0, 9, 0, 0), 0, zero_p});
		add_row('{0, 0, mk(3, 1, 0, 0, 0, 1, 0, 0, 9, 0, 0), 0, zero_p});
		add_row('{0, 0, mk(4, 1, 0, 0, 0, 1, 0, 0, 9, 0, 1), 0, zero_p});
		add_row('{1, 127, mk(11, 1, 0, 1, 1, 1, 1, 1, 1, 0, 0), 0, zero_p});
		add_row('{0, 0, mk(12, 1, 0, 1, 1, 1, 1, 1, 1, 0, 1), 0, zero_p});
		add_row('{1, 2, mk('h7FFF_FFFF, 1, 0, 0, 0, 1, '1, 0, 1, 0, 0), 0, zero_p});
		add_row('{0, 0, mk('h8000_0000, 1, 0, 0, 0, 1, 0, 0, 1, 0, 1), 0, zero_p});
		add_row('{0, 0, mk('h7FFF_FFFF, 1, 0, 0, 0, 1, 0, 0, 1, 0, 0), 0, zero_p});
		add_row('{0, 0, mk('h7FFF_FFFF, 1, 0, 0, 0, 1, 0, 0, 1, 0, 1), 0, zero_p});

		foreach (rows[i]) begin
			r = rows[i];
			if (r.wr) begin
				idle_child();
				set_children(r.cfg);
			end
			send(r.c, r.fixed, r.p);
		end
		idle_child();

		settings = '{7'd4, 7'd1, 7'd64, 7'd0, 7'd127, 7'd16, 7'd3, 7'd9};
		repeat (4)
			settings.insert(settings.size(), 7'($urandom_range(1, 64)));
		foreach (settings[s]) begin
			set_children(settings[s]);
			eff = (settings[s] > POOL_MAX) ? POOL_MAX : settings[s];
			if (eff == 0)
				eff = 1;
			budget = (eff >= 32) ? 64 : 24;
			steady = (s == 2);
			if (s == 5)
				hold_token++;
			while (budget > 0) begin
				wide = $urandom_range(0, 3) == 0;
				case ($urandom_range(0, 9))
					0: size = $urandom_range(1, eff);
					1: size = eff + $urandom_range(1, 3);
					default: size = eff;
				endcase
				for (int k = 0; k < size; k++)
					send(rand_child(wide, k == size - 1), 0, zero_p);
				budget = (budget > size) ? budget - size : 0;
			end
			steady = 0;
			idle_child();
		end

		while (parent_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/gcpa_pkg.sv
rtl/core/gcpa_if.sv
rtl/core/gcpa_div.sv
rtl/core/grid_cell_pyramid_aggregator.sv
bench/tb_top.sv
